// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/plce_pkg.sv
// Package with widths, constants and types of the packet length encoder.
`default_nettype none
package plce_pkg;

   localparam int CODE_W = 7;
   localparam int LEN_W = 11;
   localparam int ML_W = 6;
   localparam int ML_RESET = 1;
   localparam int MAX_CHARS_DEF = 44;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam int REG_MESSAGE_LENGTH = 0;

   localparam int BASE_LEN = 402;
   localparam int STEP_LEN = 20;
   localparam int UNIT_OFS = 10;
   localparam int CODE_OFS = 32;
   localparam int HDR_A = 276;
   localparam int HDR_B = 341;
   localparam int HDR_C = 342;
   localparam int HDR_D = 1302;

   localparam int TENS_MUL = 205;
   localparam int TENS_SHIFT = 11;

   localparam int QUEUE_DEPTH = 2;

   localparam int STEP_W = 4;
   localparam int STEP_HDR_PAIRS = 6;
   localparam int STEP_CHAR = 10;
   localparam int STEP_UNITS = 12;
   localparam int STEP_LAST = 13;

   typedef struct packed {
      logic             hdr;
      logic [LEN_W-1:0] hdr_c;
      logic [LEN_W-1:0] hdr_d;
      logic [LEN_W-1:0] len_t;
      logic [LEN_W-1:0] len_u;
   } desc_type;

endpackage
`default_nettype wire

// File: src/plce_if.sv
// Valid/ready channel interfaces for characters and packet lengths.
`default_nettype none
interface plce_req_if;
   logic                        valid;
   logic                        ready;
   logic [plce_pkg::CODE_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface plce_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [plce_pkg::LEN_W-1:0] packet_length;
   logic                       last_of_run;

   modport source (output valid, output packet_length, output last_of_run, input ready);
   modport sink (input valid, input packet_length, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: src/plce_front.sv
// Front end: accepts characters, tracks the index and computes the lengths.
`default_nettype none
module plce_front #(
   parameter int MAX_CHARS = plce_pkg::MAX_CHARS_DEF,
   parameter int IDX_W = $clog2(MAX_CHARS + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   plce_req_if.sink                       req_bus,
   input  wire logic [plce_pkg::ML_W-1:0] message_length,
   input  wire logic                      q_full,
   output logic                           q_push,
   output plce_pkg::desc_type             q_data
);

   logic [IDX_W-1:0] char_index_ff;
   logic [IDX_W-1:0] char_index_in;
   logic [IDX_W-1:0] n;
   logic [IDX_W-1:0] idx;
   logic [IDX_W:0]   idx_inc;
   logic [plce_pkg::CODE_W-1:0] code;
   logic [plce_pkg::CODE_W-1:0] v;
   logic [plce_pkg::CODE_W+7:0] prod;
   logic [3:0] tens;
   logic [3:0] units;
   logic [plce_pkg::LEN_W-1:0] base;

   assign req_bus.ready = !q_full;
   assign q_push = req_bus.valid && !q_full;

   always_comb begin
      if (message_length == '0) begin
         n = IDX_W'(1);
      end else if (32'(message_length) > MAX_CHARS) begin
         n = IDX_W'(MAX_CHARS);
      end else begin
         n = IDX_W'(message_length);
      end

      idx = (char_index_ff >= n) ? '0 : char_index_ff;
      idx_inc = {1'b0, idx} + 1'b1;
      char_index_in = (idx_inc >= {1'b0, n}) ? '0 : idx_inc[IDX_W-1:0];

      code = (32'(req_bus.char_code) < plce_pkg::CODE_OFS) ?
             plce_pkg::CODE_W'(plce_pkg::CODE_OFS) : req_bus.char_code;
      v = code - plce_pkg::CODE_W'(plce_pkg::CODE_OFS);
      prod = {8'b0, v} * (plce_pkg::CODE_W + 8)'(plce_pkg::TENS_MUL);
      tens = 4'(prod >> plce_pkg::TENS_SHIFT);
      units = 4'(v - plce_pkg::CODE_W'(tens) * plce_pkg::CODE_W'(10));

      base = plce_pkg::LEN_W'(plce_pkg::BASE_LEN + plce_pkg::STEP_LEN * 32'(idx));

      q_data.hdr = (idx == '0);
      q_data.hdr_c = plce_pkg::LEN_W'(plce_pkg::HDR_C + 32'(n) - 1);
      q_data.hdr_d = plce_pkg::LEN_W'(plce_pkg::HDR_D + 32'(n) - 1);
      q_data.len_t = base + plce_pkg::LEN_W'(tens);
      q_data.len_u = base + plce_pkg::LEN_W'(plce_pkg::UNIT_OFS) + plce_pkg::LEN_W'(units);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_index_ff <= '0;
      end else if (q_push) begin
         char_index_ff <= char_index_in;
      end
   end

endmodule
`default_nettype wire

// File: src/plce_queue.sv
// Short queue of character descriptors between the front and back ends.
`default_nettype none
module plce_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  plce_pkg::desc_type      push_data,
   output logic                    full,
   input  wire logic               pop,
   output plce_pkg::desc_type      head,
   output logic                    empty
);

   localparam int PTR_W = (plce_pkg::QUEUE_DEPTH > 1) ? $clog2(plce_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(plce_pkg::QUEUE_DEPTH + 1);

   plce_pkg::desc_type entry_ff [plce_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full = (count_ff == CNT_W'(plce_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(plce_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(plce_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: src/plce_back.sv
// Back end: walks each descriptor and sends one packet length per cycle while the output is not stalled.
`default_nettype none
module plce_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  plce_pkg::desc_type head,
   input  wire logic          empty,
   output logic               pop,
   plce_rsp_if.source         rsp_bus
);

   logic [plce_pkg::STEP_W-1:0] step_ff;
   logic [plce_pkg::STEP_W-1:0] step_in;
   logic [plce_pkg::STEP_W-1:0] step;
   logic                        valid_ff;
   logic                        valid_in;
   logic [plce_pkg::LEN_W-1:0]  len_ff;
   logic [plce_pkg::LEN_W-1:0]  len_in;
   logic                        last_ff;
   logic                        last_in;
   logic                        advance;
   logic                        emit;

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.packet_length = len_ff;
   assign rsp_bus.last_of_run = last_ff;

   always_comb begin
      advance = !valid_ff || rsp_bus.ready;
      emit = advance && !empty;

      step = (step_ff == '0 && !head.hdr) ?
             plce_pkg::STEP_W'(plce_pkg::STEP_CHAR) : step_ff;

      if (step < plce_pkg::STEP_W'(plce_pkg::STEP_HDR_PAIRS)) begin
         len_in = step[0] ? plce_pkg::LEN_W'(plce_pkg::HDR_B) : plce_pkg::LEN_W'(plce_pkg::HDR_A);
      end else if (step < plce_pkg::STEP_W'(plce_pkg::STEP_CHAR)) begin
         len_in = step[0] ? head.hdr_d : head.hdr_c;
      end else if (step < plce_pkg::STEP_W'(plce_pkg::STEP_UNITS)) begin
         len_in = head.len_t;
      end else begin
         len_in = head.len_u;
      end
      last_in = (step == plce_pkg::STEP_W'(plce_pkg::STEP_LAST));

      pop = emit && last_in;
      valid_in = advance ? !empty : valid_ff;
      step_in = step_ff;
      if (emit) begin
         step_in = last_in ? '0 : step + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         len_ff <= len_in;
         last_ff <= last_in;
      end
   end

endmodule
`default_nettype wire

// File: src/packet_length_char_encoder.sv
// A character's first length is registered in the descriptor queue, then in the back
// end's output register. The back end sends one packet length per cycle while not
// stalled, from a step counter that adds header steps for a message's first character.
// A two-entry descriptor queue lets the front accept while the back is busy.
// Reset is synchronous: it zeroes the index, empties the queue and output, and
// sets message_length to 1.
`default_nettype none
module packet_length_char_encoder #(
   parameter int MAX_CHARS = plce_pkg::MAX_CHARS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   plce_req_if.sink                         req_bus,
   plce_rsp_if.source                       rsp_bus,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [plce_pkg::ADDR_W-1:0] paddr,
   input  wire logic [plce_pkg::DATA_W-1:0] pwdata,
   output logic      [plce_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);

   localparam int IDX_W = $clog2(MAX_CHARS + 1);

   logic [plce_pkg::ML_W-1:0] message_length_ff;
   logic                      reg_hit;
   logic                      q_push;
   logic                      q_full;
   logic                      q_pop;
   logic                      q_empty;
   plce_pkg::desc_type        q_data;
   plce_pkg::desc_type        q_head;

   assign pready = 1'b1;
   assign reg_hit = (paddr[plce_pkg::ADDR_W-1] == 1'(plce_pkg::REG_MESSAGE_LENGTH));
   assign prdata = reg_hit ? plce_pkg::DATA_W'(message_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         message_length_ff <= plce_pkg::ML_W'(plce_pkg::ML_RESET);
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         message_length_ff <= pwdata[plce_pkg::ML_W-1:0];
      end
   end

   plce_front #(
      .MAX_CHARS (MAX_CHARS),
      .IDX_W     (IDX_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .message_length (message_length_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_data)
   );

   plce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   plce_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .empty   (q_empty),
      .pop     (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire

// File: src/plce_checker.sv
// Port-level checker for the packet length encoder and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module plce_checker (
   input wire logic   clock,
   input wire logic   reset,
   plce_req_if.sink   req_bus,
   plce_rsp_if.source rsp_bus
);

   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset,
      !rsp_bus.valid && req_bus.ready, "result valid or input stalled after reset")
   `ASSERT_NEXT(a_hold_valid, clock, reset, rsp_bus.valid && !rsp_bus.ready,
      rsp_bus.valid, "result transaction dropped while stalled")
   `ASSERT_NEXT(a_hold_payload, clock, reset, rsp_bus.valid && !rsp_bus.ready,
      $stable(rsp_bus.packet_length) && $stable(rsp_bus.last_of_run),
      "stalled result payload changed")
   `ASSERT_NOW(a_last_is_units, clock, reset, rsp_bus.valid && rsp_bus.last_of_run,
      32'(rsp_bus.packet_length) >= plce_pkg::BASE_LEN + plce_pkg::UNIT_OFS,
      "last length below units range")
   `ASSERT_NOW(a_header_not_last, clock, reset,
      rsp_bus.valid && 32'(rsp_bus.packet_length) == plce_pkg::HDR_A,
      !rsp_bus.last_of_run, "header length marked as last")

endmodule

bind packet_length_char_encoder plce_checker u_plce_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
`default_nettype wire

// File: bench/packet_length_char_encoder_tb.sv
// Self-checking testbench of the packet length character encoder.
`timescale 1ns / 100ps
module packet_length_char_encoder_tb;

   typedef struct packed {
      logic [plce_pkg::LEN_W-1:0] len;
      logic                       last;
   } length_item_type;

   typedef struct {
      bit                          wr;
      logic [plce_pkg::ML_W-1:0]   length;
      logic [plce_pkg::CODE_W-1:0] code;
      bit                          typed;
      bit                          hdr;
      logic [plce_pkg::LEN_W-1:0]  hdr_c;
      logic [plce_pkg::LEN_W-1:0]  hdr_d;
      logic [plce_pkg::LEN_W-1:0]  len_t;
      logic [plce_pkg::LEN_W-1:0]  len_u;
   } stim_row_type;

   localparam int NUM_ROWS = 25;
   localparam int RANDOM_CHARS = 150;

   // Rows with typed results carry the expected lengths; the rest use the predictor.
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{1'b0, 6'd0, 7'd32, 1'b1, 1'b1, 11'd342, 11'd1302, 11'd402, 11'd412},
      '{1'b0, 6'd0, 7'd126, 1'b1, 1'b1, 11'd342, 11'd1302, 11'd411, 11'd416},
      '{1'b0, 6'd0, 7'd127, 1'b1, 1'b1, 11'd342, 11'd1302, 11'd411, 11'd417},
      '{1'b0, 6'd0, 7'd0, 1'b1, 1'b1, 11'd342, 11'd1302, 11'd402, 11'd412},
      '{1'b0, 6'd0, 7'd31, 1'b1, 1'b1, 11'd342, 11'd1302, 11'd402, 11'd412},
      '{1'b1, 6'd44, 7'd0, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd65, 1'b1, 1'b1, 11'd385, 11'd1345, 11'd405, 11'd415},
      '{1'b0, 6'd0, 7'd66, 1'b1, 1'b0, 11'd0, 11'd0, 11'd425, 11'd436},
      '{1'b0, 6'd0, 7'd126, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd0, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd127, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b1, 6'd2, 7'd0, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd90, 1'b1, 1'b1, 11'd343, 11'd1303, 11'd407, 11'd420},
      '{1'b0, 6'd0, 7'd100, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd32, 1'b1, 1'b1, 11'd343, 11'd1303, 11'd402, 11'd412},
      '{1'b1, 6'd0, 7'd0, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd80, 1'b1, 1'b1, 11'd342, 11'd1302, 11'd406, 11'd420},
      '{1'b0, 6'd0, 7'd80, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b1, 6'd63, 7'd0, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd33, 1'b1, 1'b1, 11'd385, 11'd1345, 11'd402, 11'd413},
      '{1'b1, 6'd45, 7'd0, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd126, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b1, 6'd3, 7'd0, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd64, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{1'b0, 6'd0, 7'd64, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0}
   };

   logic                        clock;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [plce_pkg::ADDR_W-1:0] paddr;
   logic [plce_pkg::DATA_W-1:0] pwdata;
   logic [plce_pkg::DATA_W-1:0] prdata;
   logic                        pready;

   plce_req_if req_bus ();
   plce_rsp_if rsp_bus ();

   logic [plce_pkg::ML_W-1:0] length_reg;
   logic [plce_pkg::ML_W-1:0] char_idx;
   length_item_type           pending_lengths [$];
   bit                        quiet;
   bit                        failed;
   int                        rsp_hold;

   packet_length_char_encoder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic plce_pkg::desc_type encode_char(
      input logic [plce_pkg::CODE_W-1:0] code);
      plce_pkg::desc_type run;
      int n;
      int pos;
      int v;
      int base;
      n = length_reg;
      if (n < 1) n = 1;
      if (n > plce_pkg::MAX_CHARS_DEF) n = plce_pkg::MAX_CHARS_DEF;
      pos = char_idx;
      if (pos >= n) pos = 0;
      v = (code < plce_pkg::CODE_OFS) ? 0 : code - plce_pkg::CODE_OFS;
      base = plce_pkg::BASE_LEN + plce_pkg::STEP_LEN * pos;
      run.hdr = (pos == 0);
      run.hdr_c = plce_pkg::LEN_W'(plce_pkg::HDR_C + n - 1);
      run.hdr_d = plce_pkg::LEN_W'(plce_pkg::HDR_D + n - 1);
      run.len_t = plce_pkg::LEN_W'(base + v / 10);
      run.len_u = plce_pkg::LEN_W'(base + plce_pkg::UNIT_OFS + v % 10);
      pos++;
      if (pos >= n) pos = 0;
      char_idx = plce_pkg::ML_W'(pos);
      return run;
   endfunction

   function automatic void queue_lengths(input plce_pkg::desc_type run);
      if (run.hdr) begin
         for (int r = 0; r < 3; r++) begin
            pending_lengths.push_back(
               length_item_type'{plce_pkg::LEN_W'(plce_pkg::HDR_A), 1'b0});
            pending_lengths.push_back(
               length_item_type'{plce_pkg::LEN_W'(plce_pkg::HDR_B), 1'b0});
         end
         pending_lengths.push_back(length_item_type'{run.hdr_c, 1'b0});
         pending_lengths.push_back(length_item_type'{run.hdr_d, 1'b0});
         pending_lengths.push_back(length_item_type'{run.hdr_c, 1'b0});
         pending_lengths.push_back(length_item_type'{run.hdr_d, 1'b0});
      end
      pending_lengths.push_back(length_item_type'{run.len_t, 1'b0});
      pending_lengths.push_back(length_item_type'{run.len_t, 1'b0});
      pending_lengths.push_back(length_item_type'{run.len_u, 1'b0});
      pending_lengths.push_back(length_item_type'{run.len_u, 1'b1});
   endfunction

   task automatic send_char(input logic [plce_pkg::CODE_W-1:0] code, input bit typed,
                            input plce_pkg::desc_type typed_run);
      int gap;
      plce_pkg::desc_type run;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_code <= code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      run = encode_char(code);
      queue_lengths(typed ? typed_run : run);
   endtask

   task automatic drain_lengths();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_lengths.size() != 0) @(posedge clock);
   endtask

   task automatic write_length(input logic [plce_pkg::ML_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= plce_pkg::ADDR_W'(4 * plce_pkg::REG_MESSAGE_LENGTH);
      pwdata <= plce_pkg::DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      length_reg = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== plce_pkg::DATA_W'(value)) begin
         $error("message_length readback: expected %0d, got %0d", value, prdata);
         failed = 1'b1;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      length_item_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_lengths.size() == 0) begin
               $error("unexpected transaction: packet_length %0d, last_of_run %0b",
                      rsp_bus.packet_length, rsp_bus.last_of_run);
               failed = 1'b1;
            end else begin
               want = pending_lengths.pop_front();
               if (rsp_bus.packet_length !== want.len) begin
                  $error("packet_length: expected %0d, got %0d", want.len,
                         rsp_bus.packet_length);
                  failed = 1'b1;
               end
               if (rsp_bus.last_of_run !== want.last) begin
                  $error("last_of_run: expected %0b, got %0b", want.last,
                         rsp_bus.last_of_run);
                  failed = 1'b1;
               end
            end
            rsp_hold = quiet ? 0 : $urandom_range(0, 5);
         end
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("** packet_length_char_encoder: FAILED **");
      $finish;
   end

   initial begin
      plce_pkg::desc_type typed_run;
      int sent;
      int phase;
      int count;
      logic [plce_pkg::ML_W-1:0] length;
      logic [plce_pkg::CODE_W-1:0] code;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.char_code = '0;
      rsp_bus.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      quiet = 1'b0;
      failed = 1'b0;
      length_reg = plce_pkg::ML_W'(plce_pkg::ML_RESET);
      char_idx = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].wr) begin
            drain_lengths();
            write_length(directed_rows[i].length);
         end else begin
            typed_run.hdr = directed_rows[i].hdr;
            typed_run.hdr_c = directed_rows[i].hdr_c;
            typed_run.hdr_d = directed_rows[i].hdr_d;
            typed_run.len_t = directed_rows[i].len_t;
            typed_run.len_u = directed_rows[i].len_u;
            send_char(directed_rows[i].code, directed_rows[i].typed, typed_run);
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_CHARS) begin
         case (phase)
            0: begin
               length = 6'd44;
               count = 48;
            end
            1: begin
               length = 6'd63;
               count = $urandom_range(4, 16);
            end
            2: begin
               length = 6'd0;
               count = $urandom_range(4, 10);
            end
            3: begin
               length = 6'd1;
               count = $urandom_range(4, 10);
            end
            default: begin
               if ($urandom_range(0, 3) == 0) length = plce_pkg::ML_W'($urandom_range(0, 63));
               else length = plce_pkg::ML_W'($urandom_range(1, 6));
               count = $urandom_range(4, 16);
            end
         endcase
         drain_lengths();
         quiet = ($urandom_range(0, 3) == 0);
         write_length(length);
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) code = plce_pkg::CODE_W'($urandom_range(0, 127));
            else code = plce_pkg::CODE_W'($urandom_range(32, 126));
            if ($urandom_range(0, 24) == 0) drain_lengths();
            send_char(code, 1'b0, typed_run);
            sent++;
         end
         phase++;
      end

      req_bus.valid <= 1'b0;
      quiet = 1'b0;
      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (!failed && pending_lengths.size() == 0) begin
         $display("** packet_length_char_encoder: PASSED **");
      end else begin
         $display("** packet_length_char_encoder: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/plce_pkg.sv
src/plce_if.sv
src/plce_front.sv
src/plce_queue.sv
src/plce_back.sv
src/packet_length_char_encoder.sv
src/plce_checker.sv
bench/packet_length_char_encoder_tb.sv
